// ===== design/mat3_inverse_defines.svh =====
// Assertion macros for the 3x3 matrix inverse block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MAT3_INVERSE_DEFINES_SVH
`define MAT3_INVERSE_DEFINES_SVH

// Antecedent true implies consequent true in the same cycle.
`define M3_ASSERT_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Condition must never hold.
`define M3_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== design/m3inv_pkg.sv =====
// Types and constants for the 3x3 matrix inverse block.
// No dependencies.
package m3inv_pkg;

    localparam int ELEM_W = 16;
    localparam int FRAC_W = ELEM_W / 2;

    typedef logic signed [ELEM_W-1:0] elem_t;

    typedef struct packed {
        elem_t elem_0;
        elem_t elem_1;
        elem_t elem_2;
        elem_t elem_3;
        elem_t elem_4;
        elem_t elem_5;
        elem_t elem_6;
        elem_t elem_7;
        elem_t elem_8;
    } mat_in_t;

    typedef struct packed {
        elem_t inv_0;
        elem_t inv_1;
        elem_t inv_2;
        elem_t inv_3;
        elem_t inv_4;
        elem_t inv_5;
        elem_t inv_6;
        elem_t inv_7;
        elem_t inv_8;
        logic  singular;
        logic  clipped;
    } mat_out_t;

endpackage

// ===== design/mat3_inverse.sv =====
// 3x3 matrix inverse by the adjugate, fully pipelined.
// Depends on m3inv_pkg and mat3_inverse_defines.svh.
//
// Usage:
//   Input channel mat_valid / mat_stall / mat carries one matrix per item,
//   nine signed Q8.8 elements in storage order. Output channel inv_valid /
//   inv_stall / inv carries the inverse elements plus singular and clipped.
//   An item moves on an edge where valid is high and stall is low.
// Throughput: one matrix per cycle while the receiver does not stall. Nine
//   division lanes each resolve one quotient bit per stage, so there are ELEM_W division stages.
// Stages, in order: input register, products, cofactors, two determinant
//   stages, sign split, range check, ELEM_W division stages, saturation into
//   the output register.
// A zero determinant echoes the input elements with singular set.
// Reset clears all stage valid bits; the pipeline comes up empty.
// When the receiver stalls, a held result stays on inv; earlier stages
//   keep filling any empty slots, and mat_stall rises only once the
//   pipeline is full back to its first stage.
module mat3_inverse (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mat_valid,
    output logic               mat_stall,
    input  m3inv_pkg::mat_in_t mat,
    output logic               inv_valid,
    input  logic               inv_stall,
    output m3inv_pkg::mat_out_t inv
);
    import m3inv_pkg::*;

`include "mat3_inverse_defines.svh"

    localparam int W  = ELEM_W;
    localparam int F2 = 2 * FRAC_W;
    localparam int PW = 2 * W;        // element product
    localparam int CW = 2 * W + 1;    // cofactor
    localparam int LW = 2 * W + 2;    // low determinant partial
    localparam int DW = 3 * W + 2;    // determinant
    localparam int MW = 3 * W + 1;    // determinant magnitude
    localparam int NW = CW + F2;      // scaled numerator
    localparam int RW = MW + W;       // division remainder
    localparam int NS = W + 8;        // total stages
    localparam int SD = 6;            // range check stage
    localparam int SO = NS - 1;       // output stage

    // Product operand pairs; cofactor k = pr[2k] - pr[2k+1]
    localparam int PA [18] = '{4, 7, 7, 1, 1, 4, 6, 3, 0, 6, 3, 0, 3, 6, 6, 0, 0, 3};
    localparam int PB [18] = '{8, 5, 2, 8, 5, 2, 5, 8, 8, 2, 2, 5, 7, 4, 1, 7, 4, 1};

    // Stage handshake
    logic [NS-1:0] v_reg;
    logic [NS-1:0] adv;

    assign adv[NS-1] = !v_reg[NS-1] || !inv_stall;
    for (genvar k = 0; k < NS - 1; k++) begin : g_adv
        assign adv[k] = !v_reg[k] || adv[k+1];
    end

    assign mat_stall = !adv[0];
    assign inv_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) v_reg[0] <= mat_valid;
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // Input unpack
    elem_t in_e [9];
    assign in_e[0] = mat.elem_0;
    assign in_e[1] = mat.elem_1;
    assign in_e[2] = mat.elem_2;
    assign in_e[3] = mat.elem_3;
    assign in_e[4] = mat.elem_4;
    assign in_e[5] = mat.elem_5;
    assign in_e[6] = mat.elem_6;
    assign in_e[7] = mat.elem_7;
    assign in_e[8] = mat.elem_8;

    // Elements travel alongside for the singular echo
    elem_t e_reg [NS-1][9];

    always_ff @(posedge clk)
    begin
        if (adv[0]) e_reg[0] <= in_e;
    end

    for (genvar k = 1; k < NS - 1; k++) begin : g_echo
        always_ff @(posedge clk)
        begin
            if (adv[k]) e_reg[k] <= e_reg[k-1];
        end
    end

    // Stage 1: element products
    logic signed [PW-1:0] pr_reg  [18];
    logic signed [PW-1:0] pr_next [18];

    always_comb
    begin
        for (int p = 0; p < 18; p++) begin
            pr_next[p] = e_reg[0][PA[p]] * e_reg[0][PB[p]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1]) pr_reg <= pr_next;
    end

    // Stage 2: cofactors
    logic signed [CW-1:0] cof2_reg  [9];
    logic signed [CW-1:0] cof2_next [9];

    always_comb
    begin
        for (int i = 0; i < 9; i++) begin
            cof2_next[i] = CW'(pr_reg[2*i]) - CW'(pr_reg[2*i+1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2]) cof2_reg <= cof2_next;
    end

    // Stage 3: determinant partials, cofactor split at bit W+1
    logic signed [LW-1:0] pl_reg  [3];
    logic signed [LW-1:0] pl_next [3];
    logic signed [PW-1:0] ph_reg  [3];
    logic signed [PW-1:0] ph_next [3];
    logic signed [CW-1:0] cof3_reg [9];

    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            pl_next[i] = e_reg[2][3*i] * $signed({1'b0, cof2_reg[i][W:0]});
            ph_next[i] = e_reg[2][3*i] * $signed(cof2_reg[i][CW-1:W+1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3]) begin
            pl_reg   <= pl_next;
            ph_reg   <= ph_next;
            cof3_reg <= cof2_reg;
        end
    end

    // Stage 4: determinant sum
    logic signed [DW-1:0] det_reg;
    logic signed [DW-1:0] det_next;
    logic signed [CW-1:0] cof4_reg [9];

    always_comb
    begin
        det_next = (DW'(ph_reg[0]) <<< (W + 1)) + DW'(pl_reg[0])
                 + (DW'(ph_reg[1]) <<< (W + 1)) + DW'(pl_reg[1])
                 + (DW'(ph_reg[2]) <<< (W + 1)) + DW'(pl_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[4]) begin
            det_reg  <= det_next;
            cof4_reg <= cof3_reg;
        end
    end

    // Stage 5: signs and magnitudes, numerators scaled by 2^(2F)
    logic signed [DW-1:0] det_abs;
    logic [MW-1:0]        dmag5_reg;
    logic                 zero5_reg;
    logic [8:0]           neg5_reg;
    logic [8:0]           neg5_next;
    logic [NW-1:0]        num5_reg  [9];
    logic [NW-1:0]        num5_next [9];
    logic signed [CW-1:0] cabs;

    always_comb
    begin
        det_abs = det_reg[DW-1] ? -det_reg : det_reg;
        for (int i = 0; i < 9; i++) begin
            cabs         = cof4_reg[i][CW-1] ? -cof4_reg[i] : cof4_reg[i];
            num5_next[i] = {cabs, {F2{1'b0}}};
            neg5_next[i] = cof4_reg[i][CW-1] ^ det_reg[DW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5]) begin
            dmag5_reg <= det_abs[MW-1:0];
            zero5_reg <= (det_reg == '0);
            neg5_reg  <= neg5_next;
            num5_reg  <= num5_next;
        end
    end

    // Division side band, index s belongs to stage SD + s
    logic [MW-1:0] dmag_reg [W+1];
    logic          zero_reg [W+1];
    logic [8:0]    neg_reg  [W+1];
    logic [8:0]    ovf_reg  [W+1];
    logic [RW-1:0] rem_reg  [W+1][9];
    logic [W-1:0]  q_reg    [1:W][9];

    // Stage 6: quotient of 2^W or more saturates unless the determinant is zero
    always_ff @(posedge clk)
    begin
        if (adv[SD]) begin
            dmag_reg[0] <= dmag5_reg;
            zero_reg[0] <= zero5_reg;
            neg_reg[0]  <= neg5_reg;
            for (int i = 0; i < 9; i++) begin
                rem_reg[0][i] <= RW'(num5_reg[i]);
                ovf_reg[0][i] <= RW'(num5_reg[i]) >= {dmag5_reg, {W{1'b0}}};
            end
        end
    end

    // Restoring division, one quotient bit per stage and lane
    for (genvar j = 0; j < W; j++) begin : g_div
        logic [RW-1:0] trial;
        logic [RW-1:0] rem_next [9];
        logic [W-1:0]  q_next   [9];
        logic [W-1:0]  q_prev   [9];

        assign trial = RW'(dmag_reg[j]) << (W - 1 - j);

        always_comb
        begin
            for (int i = 0; i < 9; i++) begin
                if (j == 0) q_prev[i] = '0;
                else        q_prev[i] = q_reg[(j == 0) ? 1 : j][i];
                if (rem_reg[j][i] >= trial) begin
                    rem_next[i] = rem_reg[j][i] - trial;
                    q_next[i]   = q_prev[i] | (W'(1) << (W - 1 - j));
                end else begin
                    rem_next[i] = rem_reg[j][i];
                    q_next[i]   = q_prev[i];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[SD+1+j]) begin
                dmag_reg[j+1] <= dmag_reg[j];
                zero_reg[j+1] <= zero_reg[j];
                neg_reg[j+1]  <= neg_reg[j];
                ovf_reg[j+1]  <= ovf_reg[j];
                rem_reg[j+1]  <= rem_next;
                q_reg[j+1]    <= q_next;
            end
        end
    end

    // Output stage: sign, saturation, singular echo
    elem_t inv_reg  [9];
    elem_t inv_next [9];
    logic  sing_reg;
    logic  clip_reg;
    logic  clip_next;
    logic [W-1:0] qf;

    always_comb
    begin
        clip_next = 1'b0;
        for (int i = 0; i < 9; i++) begin
            qf = q_reg[W][i];
            if (zero_reg[W]) begin
                inv_next[i] = e_reg[NS-2][i];
            end else if (neg_reg[W][i]) begin
                if (ovf_reg[W][i] || (qf[W-1] && (qf[W-2:0] != '0))) begin
                    inv_next[i] = {1'b1, {(W-1){1'b0}}};
                    clip_next   = 1'b1;
                end else begin
                    inv_next[i] = -qf;
                end
            end else begin
                if (ovf_reg[W][i] || qf[W-1]) begin
                    inv_next[i] = {1'b0, {(W-1){1'b1}}};
                    clip_next   = 1'b1;
                end else begin
                    inv_next[i] = qf;
                end
            end
        end
        if (zero_reg[W]) clip_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv[SO]) begin
            inv_reg  <= inv_next;
            sing_reg <= zero_reg[W];
            clip_reg <= clip_next;
        end
    end

    assign inv.inv_0    = inv_reg[0];
    assign inv.inv_1    = inv_reg[1];
    assign inv.inv_2    = inv_reg[2];
    assign inv.inv_3    = inv_reg[3];
    assign inv.inv_4    = inv_reg[4];
    assign inv.inv_5    = inv_reg[5];
    assign inv.inv_6    = inv_reg[6];
    assign inv.inv_7    = inv_reg[7];
    assign inv.inv_8    = inv_reg[8];
    assign inv.singular = sing_reg;
    assign inv.clipped  = clip_reg;

    // Checks
    `M3_ASSERT_NEVER(a_sing_clip, inv_valid && inv.singular && inv.clipped, "singular and clipped")
    `M3_ASSERT_IMPLY(a_stall_full, mat_stall, v_reg[0], "input stalled with first stage empty")
    `M3_ASSERT_IMPLY(a_empty_ready, !inv_valid, !mat_stall, "input stalled with output empty")

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for mat3_inverse: random and directed 3x3 matrices.
// Depends on m3inv_pkg and the mat3_inverse RTL; predicts each inverse in-bench.
`timescale 1ns / 1ps

module tb_top;
    import m3inv_pkg::*;

    localparam int LATENCY = ELEM_W + 7;

    logic     clk;
    logic     rst_n;
    logic     mat_valid;
    logic     mat_stall;
    mat_in_t  mat;
    logic     inv_valid;
    logic     inv_stall;
    mat_out_t inv;

    mat3_inverse u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat_valid (mat_valid),
        .mat_stall (mat_stall),
        .mat       (mat),
        .inv_valid (inv_valid),
        .inv_stall (inv_stall),
        .inv       (inv)
    );

    mat_in_t  pending_mats[$];
    mat_out_t expected_invs[$];
    int       fail_count;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       hold_cycles;
    bit       stim_done;
    bit       mat_taken;

    // Clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Exact inverse prediction: adjugate over determinant, truncate, saturate
    function automatic mat_out_t predict_inverse(mat_in_t m);
        mat_out_t           r;
        logic signed [63:0] e[9];
        logic signed [63:0] c[9];
        logic signed [127:0] det;
        logic signed [127:0] q;
        logic               clip;
        elem_t              v[9];
        e[0] = m.elem_0; e[1] = m.elem_1; e[2] = m.elem_2;
        e[3] = m.elem_3; e[4] = m.elem_4; e[5] = m.elem_5;
        e[6] = m.elem_6; e[7] = m.elem_7; e[8] = m.elem_8;
        c[0] = e[4]*e[8] - e[7]*e[5];
        c[1] = e[7]*e[2] - e[1]*e[8];
        c[2] = e[1]*e[5] - e[4]*e[2];
        c[3] = e[6]*e[5] - e[3]*e[8];
        c[4] = e[0]*e[8] - e[6]*e[2];
        c[5] = e[3]*e[2] - e[0]*e[5];
        c[6] = e[3]*e[7] - e[6]*e[4];
        c[7] = e[6]*e[1] - e[0]*e[7];
        c[8] = e[0]*e[4] - e[3]*e[1];
        det = 128'(e[0])*128'(c[0]) + 128'(e[3])*128'(c[1]) + 128'(e[6])*128'(c[2]);
        clip = 1'b0;
        if (det == 0)
        begin
            r = '{inv_0: m.elem_0, inv_1: m.elem_1, inv_2: m.elem_2,
                  inv_3: m.elem_3, inv_4: m.elem_4, inv_5: m.elem_5,
                  inv_6: m.elem_6, inv_7: m.elem_7, inv_8: m.elem_8,
                  singular: 1'b1, clipped: 1'b0};
            return r;
        end
        for (int i = 0; i < 9; i++)
        begin
            // signed division truncates toward zero
            q = (128'(c[i]) <<< (2*FRAC_W)) / det;
            if (q > 128'sd32767)
            begin
                q = 128'sd32767;
                clip = 1'b1;
            end
            else if (q < -128'sd32768)
            begin
                q = -128'sd32768;
                clip = 1'b1;
            end
            v[i] = q[ELEM_W-1:0];
        end
        r = '{inv_0: v[0], inv_1: v[1], inv_2: v[2], inv_3: v[3], inv_4: v[4],
              inv_5: v[5], inv_6: v[6], inv_7: v[7], inv_8: v[8],
              singular: 1'b0, clipped: clip};
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic elem_t rand_elem();
        case ($urandom_range(0, 5))
            0: return elem_t'($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
            1: return elem_t'($signed($urandom_range(0, 1023)) - 512);
            2: return elem_t'($signed($urandom_range(0, 1)) * 512 - 256);
            default: return elem_t'($urandom);
        endcase
    endfunction

    function automatic mat_in_t rand_mat();
        mat_in_t m;
        m = '{rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
              rand_elem(), rand_elem(), rand_elem(), rand_elem()};
        // some singular ones: repeated row or zero column
        case ($urandom_range(0, 9))
            0:
            begin
                m.elem_3 = m.elem_0; m.elem_4 = m.elem_1; m.elem_5 = m.elem_2;
            end
            1:
            begin
                m.elem_0 = '0; m.elem_3 = '0; m.elem_6 = '0;
            end
            default: ;
        endcase
        return m;
    endfunction

    // Driver: offers the head of the queue, changes only on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            mat_valid <= 1'b0;
        else if (!mat_valid || mat_taken)
        begin
            if (mat_valid)
                void'(pending_mats.pop_front());
            if (pending_mats.size() > 0
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                mat_valid <= 1'b1;
                mat       <= pending_mats[0];
            end
            else
                mat_valid <= 1'b0;
        end
    end

    // Receiver stall, with an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            inv_stall   <= 1'b1;
        end
        else
            inv_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Monitor: prediction on input acceptance, check on output acceptance
    always @(posedge clk)
    begin
        mat_out_t want;
        mat_taken <= rst_n && mat_valid && !mat_stall;
        if (rst_n && mat_valid && !mat_stall)
            expected_invs.push_back(predict_inverse(mat));
        if (rst_n && inv_valid && !inv_stall)
        begin
            if (expected_invs.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                fail_count++;
            end
            else
            begin
                want = expected_invs.pop_front();
                if (inv.inv_0 !== want.inv_0) report_mismatch("inv_0", inv.inv_0, want.inv_0);
                if (inv.inv_1 !== want.inv_1) report_mismatch("inv_1", inv.inv_1, want.inv_1);
                if (inv.inv_2 !== want.inv_2) report_mismatch("inv_2", inv.inv_2, want.inv_2);
                if (inv.inv_3 !== want.inv_3) report_mismatch("inv_3", inv.inv_3, want.inv_3);
                if (inv.inv_4 !== want.inv_4) report_mismatch("inv_4", inv.inv_4, want.inv_4);
                if (inv.inv_5 !== want.inv_5) report_mismatch("inv_5", inv.inv_5, want.inv_5);
                if (inv.inv_6 !== want.inv_6) report_mismatch("inv_6", inv.inv_6, want.inv_6);
                if (inv.inv_7 !== want.inv_7) report_mismatch("inv_7", inv.inv_7, want.inv_7);
                if (inv.inv_8 !== want.inv_8) report_mismatch("inv_8", inv.inv_8, want.inv_8);
                if (inv.singular !== want.singular)
                    report_mismatch("singular", inv.singular, want.singular);
                if (inv.clipped !== want.clipped)
                    report_mismatch("clipped", inv.clipped, want.clipped);
            end
        end
    end

    task automatic wait_drained();
        while (pending_mats.size() > 0 || mat_valid)
            @(posedge clk);
    endtask

    // Stimulus and sequencing
    initial
    begin
        mat_in_t m;
        clk            = 1'b0;
        rst_n          = 1'b0;
        mat_valid      = 1'b0;
        mat            = '0;
        inv_stall      = 1'b0;
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        stim_done      = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: identity, scaled, extremes, singular, clipping
        m = '0; m.elem_0 = 16'sh0100; m.elem_4 = 16'sh0100; m.elem_8 = 16'sh0100;
        pending_mats.push_back(m);
        m = '0; m.elem_0 = 16'sh0200; m.elem_4 = -16'sh0080; m.elem_8 = 16'sh0400;
        pending_mats.push_back(m);
        pending_mats.push_back('0);
        pending_mats.push_back({9{16'sh7fff}});
        pending_mats.push_back({9{16'sh8000}});
        pending_mats.push_back({9{16'shffff}});
        m = '0; m.elem_0 = 16'sh0001; m.elem_4 = 16'sh0001; m.elem_8 = 16'sh0001;
        pending_mats.push_back(m);
        m = '0; m.elem_0 = 16'sh7fff; m.elem_4 = 16'sh7fff; m.elem_8 = 16'sh7fff;
        pending_mats.push_back(m);
        m = '0; m.elem_0 = 16'sh8000; m.elem_4 = 16'sh8000; m.elem_8 = 16'sh8000;
        pending_mats.push_back(m);
        m = '0; m.elem_2 = 16'sh0100; m.elem_4 = 16'sh0100; m.elem_6 = 16'sh0100;
        pending_mats.push_back(m);
        m = '{16'sh7fff, 16'sh8000, 16'sh5555, 16'shaaaa, 16'sh7fff, 16'sh0001,
              16'sh8000, 16'sh1234, 16'sh7fff};
        pending_mats.push_back(m);
        m = '{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
              16'shaaaa, 16'sh5555, 16'sh0000};
        pending_mats.push_back(m);
        wait_drained();

        // Random phases with different idling
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                3: begin send_idle_pct = 17; recv_stall_pct = 17; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int i = 0; i < 120; i++)
                pending_mats.push_back(rand_mat());
            // long hold-off on the last phase so the pipeline backs up
            if (ph == 4)
            begin
                @(negedge clk);
                hold_cycles = 4 * LATENCY;
            end
            wait_drained();
        end
        stim_done = 1'b1;
    end

    // End of run once everything has come out
    initial
    begin
        wait (stim_done);
        while (expected_invs.size() > 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        if (fail_count == 0 && expected_invs.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
